>>> sv/crcfb_pkg.sv
// ----------------------------------------------------------------------------
// crcfb_pkg
// Shared constants, codes and the CRC-16/MODBUS byte update for the frame
// builder.
// ----------------------------------------------------------------------------
package crcfb_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned CRC_W    = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned STEP_W   = 3;

  localparam int unsigned S_TDATA_W = 32;
  localparam int unsigned M_TDATA_W = 8;
  localparam int unsigned M_TUSER_W = 4;

  localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hAA;
  localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h55;
  localparam logic [CRC_W-1:0]  CRC_INIT    = 16'hFFFF;
  localparam logic [CRC_W-1:0]  CRC_POLY    = 16'hA001;

  localparam logic CMD_BEGIN   = 1'b0;
  localparam logic CMD_PAYLOAD = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_FRAME   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FRAME_OPEN = 2'd2;

  // Reflected CRC-16 update, one byte.
  function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> sv/crc16_frame_builder.sv
// ----------------------------------------------------------------------------
// crc16_frame_builder
// Serializes link frames: AA 55 type len_lo len_hi payload crc_lo crc_hi,
// CRC-16/MODBUS over header and payload.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                              tuser                        tlast
//  s_axis    in   type[7:0] len[23:8] data[31:24]    cmd                          -
//  m_axis    out  out_byte[7:0]                      byte_valid, frame_done,      last_of_run
//                                                    status[3:2]
//
// One result per cycle on m_axis while an item is in work and m_axis does not
// stall. An item gives as many results as it needs: 1 for payload or error, 3
// when it closes a frame, 5 or 7 for a begin. The next item is taken in the
// cycle its predecessor's last result moves to the output register. Reset
// (rst_ni low, async) closes any frame and empties both stages. A stall on
// m_axis holds the output register and the item in work.
module crc16_frame_builder (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [crcfb_pkg::S_TDATA_W-1:0]  s_axis_tdata,   // frame_type, payload_length, data_byte
  input  logic                             s_axis_tuser,   // cmd
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [crcfb_pkg::M_TDATA_W-1:0]  m_axis_tdata,   // out_byte
  output logic [crcfb_pkg::M_TUSER_W-1:0]  m_axis_tuser,   // byte_valid, frame_done, status[1:0]
  output logic                             m_axis_tlast    // last_of_run
);
  import crcfb_pkg::*;

  localparam logic [STEP_W-1:0] STEP_0 = 3'd0;
  localparam logic [STEP_W-1:0] STEP_1 = 3'd1;
  localparam logic [STEP_W-1:0] STEP_2 = 3'd2;
  localparam logic [STEP_W-1:0] STEP_3 = 3'd3;
  localparam logic [STEP_W-1:0] STEP_4 = 3'd4;
  localparam logic [STEP_W-1:0] STEP_5 = 3'd5;
  localparam logic [STEP_W-1:0] STEP_6 = 3'd6;

  // frame state
  logic              frame_open_q, frame_open_d;
  logic [LEN_W-1:0]  bytes_left_q, bytes_left_d;
  logic [CRC_W-1:0]  crc_q, crc_d;

  // item in work
  logic              cur_valid_q;
  logic              cur_cmd_q;
  logic [BYTE_W-1:0] cur_type_q;
  logic [LEN_W-1:0]  cur_len_q;
  logic [BYTE_W-1:0] cur_data_q;
  logic [STEP_W-1:0] step_q;

  // output register
  logic                m_valid_q;
  logic [BYTE_W-1:0]   m_byte_q;
  logic                m_bvalid_q;
  logic                m_done_q;
  logic                m_last_q;
  logic [STATUS_W-1:0] m_status_q;

  logic                out_free, advance, s_accept;
  logic [BYTE_W-1:0]   res_byte;
  logic                res_bvalid, res_done, res_last;
  logic [STATUS_W-1:0] res_status;
  logic                crc_upd;
  logic [CRC_W-1:0]    crc_in;

  assign out_free      = !m_valid_q || m_axis_tready;
  assign advance       = cur_valid_q && out_free;
  assign s_axis_tready = !cur_valid_q || (advance && res_last);
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_comb begin
    res_byte     = '0;
    res_bvalid   = 1'b1;
    res_done     = 1'b0;
    res_last     = 1'b0;
    res_status   = STATUS_OK;
    crc_upd      = 1'b0;
    crc_in       = crc_q;
    frame_open_d = frame_open_q;
    bytes_left_d = bytes_left_q;
    if (step_q == STEP_0 && cur_cmd_q == CMD_BEGIN && frame_open_q) begin
      res_bvalid = 1'b0;
      res_last   = 1'b1;
      res_status = STATUS_FRAME_OPEN;
    end else if (step_q == STEP_0 && cur_cmd_q == CMD_PAYLOAD && !frame_open_q) begin
      res_bvalid = 1'b0;
      res_last   = 1'b1;
      res_status = STATUS_NO_FRAME;
    end else if (cur_cmd_q == CMD_BEGIN) begin
      case (step_q)
        STEP_0: begin
          res_byte = SYNC_FIRST;
          crc_in   = CRC_INIT;
          crc_upd  = 1'b1;
        end
        STEP_1: begin
          res_byte = SYNC_SECOND;
          crc_upd  = 1'b1;
        end
        STEP_2: begin
          res_byte = cur_type_q;
          crc_upd  = 1'b1;
        end
        STEP_3: begin
          res_byte = cur_len_q[7:0];
          crc_upd  = 1'b1;
        end
        STEP_4: begin
          res_byte = cur_len_q[15:8];
          crc_upd  = 1'b1;
          if (cur_len_q != '0) begin
            res_last     = 1'b1;
            frame_open_d = 1'b1;
            bytes_left_d = cur_len_q;
          end
        end
        STEP_5: begin
          res_byte = crc_q[7:0];
        end
        STEP_6: begin
          res_byte     = crc_q[15:8];
          res_done     = 1'b1;
          res_last     = 1'b1;
          frame_open_d = 1'b0;
          bytes_left_d = '0;
        end
        default: begin
          res_bvalid = 1'b0;
          res_last   = 1'b1;
        end
      endcase
    end else begin
      case (step_q)
        STEP_0: begin
          res_byte     = cur_data_q;
          crc_upd      = 1'b1;
          bytes_left_d = bytes_left_q - 1'b1;
          res_last     = (bytes_left_q != 16'd1);
        end
        STEP_1: begin
          res_byte = crc_q[7:0];
        end
        STEP_2: begin
          res_byte     = crc_q[15:8];
          res_done     = 1'b1;
          res_last     = 1'b1;
          frame_open_d = 1'b0;
          bytes_left_d = '0;
        end
        default: begin
          res_bvalid = 1'b0;
          res_last   = 1'b1;
        end
      endcase
    end
    if (crc_upd) begin
      crc_d = crc16_byte(crc_in, res_byte);
    end else if (res_done) begin
      crc_d = CRC_INIT;
    end else begin
      crc_d = crc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_open_q <= 1'b0;
      bytes_left_q <= '0;
      crc_q        <= CRC_INIT;
      cur_valid_q  <= 1'b0;
      step_q       <= STEP_0;
      m_valid_q    <= 1'b0;
    end else begin
      if (advance) begin
        frame_open_q <= frame_open_d;
        bytes_left_q <= bytes_left_d;
        crc_q        <= crc_d;
      end
      if (s_accept) begin
        cur_valid_q <= 1'b1;
        step_q      <= STEP_0;
      end else if (advance) begin
        if (res_last) begin
          cur_valid_q <= 1'b0;
          step_q      <= STEP_0;
        end else begin
          step_q <= step_q + 1'b1;
        end
      end
      if (advance) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      cur_cmd_q  <= s_axis_tuser;
      cur_type_q <= s_axis_tdata[7:0];
      cur_len_q  <= s_axis_tdata[23:8];
      cur_data_q <= s_axis_tdata[31:24];
    end
    if (advance) begin
      m_byte_q   <= res_byte;
      m_bvalid_q <= res_bvalid;
      m_done_q   <= res_done;
      m_last_q   <= res_last;
      m_status_q <= res_status;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_byte_q;
  assign m_axis_tuser  = {m_status_q, m_done_q, m_bvalid_q};
  assign m_axis_tlast  = m_last_q;

endmodule

>>> sv/crcfb_checker.sv
// ----------------------------------------------------------------------------
// crcfb_checker
// Port-level checks for the frame builder's result stream.
// ----------------------------------------------------------------------------
module crcfb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [3:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  // stalled item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("m_axis item changed while stalled");

  // error item stands alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && !m_axis_tuser[1]
      && m_axis_tuser[3:2] != 2'd0 && m_axis_tdata == 8'd0)
    else $error("malformed error item");

  // frame end closes the run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast && m_axis_tuser[0])
    else $error("frame end without run end");

  // frame bytes carry ok status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[3:2] == 2'd0)
    else $error("frame byte with error status");

endmodule

bind crc16_frame_builder crcfb_checker u_crcfb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

>>> bench/tb_crc16_frame_builder.sv
// ----------------------------------------------------------------------------
// tb_crc16_frame_builder
// Self-checking bench for the CRC-16 link frame builder. Items are driven on
// the input stream and each one updates a predictor of the frame state and
// CRC; its output bytes are queued and compared with every byte leaving the
// output stream. Covers empty, short, long and random frames,
// orphan payload and nested begin errors, random idling on both sides, a
// long output hold-off and a stretch with no idling.
// ----------------------------------------------------------------------------
module tb_crc16_frame_builder;
  timeunit 1ns;
  timeprecision 1ps;

  import crcfb_pkg::*;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       frame_done;
    logic       last_of_run;
    logic [1:0] status;
  } frame_out_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // frame_type[7:0], payload_length[23:8], data_byte[31:24]
  logic        s_axis_tuser;   // cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // out_byte
  logic [3:0]  m_axis_tuser;   // byte_valid, frame_done, status[1:0]
  logic        m_axis_tlast;   // last_of_run

  frame_out_t  expected_bytes[$];
  frame_out_t  oldest_byte;
  logic        frame_is_open;
  logic [15:0] payload_left;
  logic [15:0] running_crc;
  int          mismatch_count;
  int          items_sent;
  int          hold_cycles_req;
  bit          idle_on;

  crc16_frame_builder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Bit-serial CRC-16/MODBUS update, LSB first.
  function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic frame_out_t framed_byte(input logic [7:0] b);
    frame_out_t r;
    running_crc = crc16_next(running_crc, b);
    r = '{out_byte: b, byte_valid: 1'b1, frame_done: 1'b0, last_of_run: 1'b0,
          status: STATUS_OK};
    return r;
  endfunction

  task automatic predict_link_output(input logic cmd, input logic [7:0] ftype,
                                     input logic [15:0] plen, input logic [7:0] dbyte);
    frame_out_t res[7];
    logic [7:0] hdr[5];
    int         n;
    int         i;
    logic       close_now;
    n = 0;
    close_now = 1'b0;
    hdr = '{SYNC_FIRST, SYNC_SECOND, ftype, plen[7:0], plen[15:8]};
    if ((cmd == CMD_BEGIN) == frame_is_open) begin
      res[0] = '{out_byte: 8'h00, byte_valid: 1'b0, frame_done: 1'b0, last_of_run: 1'b0,
                 status: (cmd == CMD_BEGIN) ? STATUS_FRAME_OPEN : STATUS_NO_FRAME};
      n = 1;
    end else if (cmd == CMD_BEGIN) begin
      running_crc = CRC_INIT;
      for (i = 0; i < 5; i++) begin
        res[n] = framed_byte(hdr[i]);
        n++;
      end
      close_now = (plen == 16'd0);
      frame_is_open = (plen != 16'd0);
      payload_left = plen;
    end else begin
      res[0] = framed_byte(dbyte);
      n = 1;
      payload_left = payload_left - 16'd1;
      close_now = (payload_left == 16'd0);
    end
    if (close_now) begin
      res[n]     = '{out_byte: running_crc[7:0], byte_valid: 1'b1, frame_done: 1'b0,
                     last_of_run: 1'b0, status: STATUS_OK};
      res[n + 1] = '{out_byte: running_crc[15:8], byte_valid: 1'b1, frame_done: 1'b1,
                     last_of_run: 1'b0, status: STATUS_OK};
      n += 2;
      frame_is_open = 1'b0;
      payload_left = 16'd0;
      running_crc = CRC_INIT;
    end
    res[n - 1].last_of_run = 1'b1;
    for (i = 0; i < n; i++) begin
      expected_bytes.push_back(res[i]);
    end
  endtask

  task automatic send_item(input logic cmd, input logic [7:0] ftype,
                           input logic [15:0] plen, input logic [7:0] dbyte);
    int gap;
    gap = (idle_on && $urandom_range(0, 99) < 21) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {dbyte, plen, ftype};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_link_output(cmd, ftype, plen, dbyte);
    items_sent++;
  endtask

  task automatic send_payload(input logic [7:0] dbyte);
    send_item(CMD_PAYLOAD, 8'($urandom), 16'($urandom), dbyte);
  endtask

  task automatic send_begin(input logic [7:0] ftype, input logic [15:0] plen);
    send_item(CMD_BEGIN, ftype, plen, 8'($urandom));
  endtask

  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_bytes.size() != 0) @(posedge clk_i);
  endtask

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected item, expected none, got byte %0h user %0h last %0b",
                 $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
        mismatch_count++;
      end else begin
        oldest_byte = expected_bytes.pop_front();
        compare_field("out_byte", oldest_byte.out_byte, m_axis_tdata);
        compare_field("byte_valid", oldest_byte.byte_valid, m_axis_tuser[0]);
        compare_field("frame_done", oldest_byte.frame_done, m_axis_tuser[1]);
        compare_field("status", oldest_byte.status, m_axis_tuser[3:2]);
        compare_field("last_of_run", oldest_byte.last_of_run, m_axis_tlast);
      end
    end
  end

  // Output side: random stalls, plus a long hold-off on request.
  initial begin
    int hold_len;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles_req > 0) begin
        hold_len = hold_cycles_req;
        hold_cycles_req = 0;
        m_axis_tready <= 1'b0;
        repeat (hold_len) @(posedge clk_i);
      end else begin
        m_axis_tready <= !(idle_on && $urandom_range(0, 99) < 21);
      end
    end
  end

  task automatic test_orphan_payload();
    send_payload(8'hFF);
    send_item(CMD_PAYLOAD, 8'h00, 16'h0000, 8'h00);
    wait_results_drained();
  endtask

  task automatic test_empty_frames();
    send_begin(8'h00, 16'h0000);
    send_begin(8'hFF, 16'h0000);
    wait_results_drained();
  endtask

  task automatic test_short_frames();
    send_begin(8'h5A, 16'h0001);
    send_payload(8'h00);
    send_begin(8'hA5, 16'h0003);
    send_payload(8'hFF);
    send_item(CMD_BEGIN, 8'hFF, 16'hFFFF, 8'hFF);
    send_payload(8'h80);
    send_payload(8'h01);
    send_payload(8'h7E);
    wait_results_drained();
  endtask

  task automatic test_long_frame();
    int k;
    send_begin(8'hC3, 16'h0100);
    for (k = 0; k < 256; k++) begin
      if (k == 100) begin
        send_begin(8'($urandom), 16'($urandom));
      end
      send_payload(8'($urandom));
    end
    wait_results_drained();
  endtask

  task automatic test_back_to_back();
    int f;
    int k;
    idle_on = 1'b0;
    for (f = 0; f < 3; f++) begin
      send_begin(8'($urandom), 16'd20);
      for (k = 0; k < 20; k++) begin
        send_payload(8'($urandom));
      end
    end
    wait_results_drained();
    idle_on = 1'b1;
  endtask

  task automatic test_output_hold();
    int k;
    hold_cycles_req = 300;
    send_begin(8'($urandom), 16'd40);
    for (k = 0; k < 40; k++) begin
      send_payload(8'($urandom));
    end
    wait_results_drained();
  endtask

  task automatic test_random_traffic();
    int target;
    int plen;
    int pick;
    int k;
    target = items_sent + 85;
    while (items_sent < target) begin
      if ($urandom_range(0, 99) < 8) begin
        send_payload(8'($urandom));
      end
      pick = $urandom_range(0, 99);
      plen = (pick < 15) ? 0 : (pick < 88) ? $urandom_range(1, 8)
           : (pick < 98) ? $urandom_range(9, 60) : $urandom_range(61, 120);
      send_begin(8'($urandom), 16'(plen));
      for (k = 0; k < plen; k++) begin
        if ($urandom_range(0, 99) < 4) begin
          send_begin(8'($urandom), 16'($urandom));
        end
        if ($urandom_range(0, 999) < 5) begin
          break;
        end
        send_payload(8'($urandom));
      end
    end
    wait_results_drained();
  endtask

  initial begin
    int guard;
    rst_ni          = 1'b0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    s_axis_tuser    = CMD_BEGIN;
    frame_is_open   = 1'b0;
    payload_left    = 16'd0;
    running_crc     = CRC_INIT;
    mismatch_count  = 0;
    items_sent      = 0;
    hold_cycles_req = 0;
    idle_on         = 1'b1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_orphan_payload();
    test_empty_frames();
    test_short_frames();
    test_long_frame();
    test_back_to_back();
    test_output_hold();
    test_random_traffic();

    guard = 0;
    while (expected_bytes.size() != 0 && guard < 10000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0 && expected_bytes.size() == 0) begin
      $display("[crc16_frame_builder] OK");
    end else begin
      $display("[crc16_frame_builder] ERROR");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("[crc16_frame_builder] ERROR");
    $finish;
  end

endmodule

>>> crc16_frame_builder.f
sv/crcfb_pkg.sv
sv/crc16_frame_builder.sv
sv/crcfb_checker.sv
bench/tb_crc16_frame_builder.sv
